@@ rtl/timed_release_delay_queue_macros.svh @@
// Assertion macros for the timed release delay queue.
// Used by the top level; needs a clock named clock and a reset named reset in scope.
`ifndef TIMED_RELEASE_DELAY_QUEUE_MACROS_SVH
`define TIMED_RELEASE_DELAY_QUEUE_MACROS_SVH
`ifndef SYNTH
`define TRDQ_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timed_release_delay_queue: check failed");
`define TRDQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timed_release_delay_queue: check failed");
`else
`define TRDQ_ASSERT_IMP(lbl, ante, cons)
`define TRDQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/tdq_pkg.sv @@
// Shared types and codes for the timed release delay queue.
// No dependencies; used by tdq_cell and timed_release_delay_queue.
package tdq_pkg;

   localparam logic [1:0] ACT_INSERT  = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_CLEAR   = 2'd2;

   localparam logic [2:0] KIND_ACCEPTED   = 3'd0;
   localparam logic [2:0] KIND_REFUSED    = 3'd1;
   localparam logic [2:0] KIND_RELEASED   = 3'd2;
   localparam logic [2:0] KIND_NONE_READY = 3'd3;
   localparam logic [2:0] KIND_CLEARED    = 3'd4;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      logic valid;
      logic ge;
      logic rdy;
   } cell_flags_type;

   typedef enum logic {
      ST_IDLE,
      ST_RELEASE
   } state_type;

endpackage

@@ rtl/timed_release_delay_queue.sv @@
// Timed release delay queue: a row of cells kept sorted by delivery time.
// Insert takes one transaction on req_ and gives one result on rsp_: accepted,
// or refused when all QUEUE_DEPTH cells are full. A new entry lands ahead of
// stored entries with the same time. Release gives one released result per
// entry whose time is at most req_time_stamp, in time order, last set on the
// final one; with none ready it gives a single nothing-ready result. Clear
// empties the queue and gives one cleared result. Action three gives nothing.
// A release is accepted first and then gives its results in order: the head cell is
// popped once per cycle while the output register is free, the whole row shifts
// toward it, and req_stall stays high until the release ends.
// Results leave through one output register, so each result is visible the
// cycle after it is formed. While a result waits with rsp_stall high, the output
// register holds, the row holds, and req_stall stays high.
// Reset empties the queue at once and drops any pending result.
module timed_release_delay_queue import tdq_pkg::*; #(
   parameter int QUEUE_DEPTH = 64,
   parameter int TAG_BITS    = 16,
   parameter int TIME_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_packet_tag,
   input  logic [31:0] req_time_stamp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_packet_tag_res,
   output logic [31:0] rsp_delivery_time,
   output logic [6:0]  rsp_occupancy,
   output logic        rsp_last
);

`include "timed_release_delay_queue_macros.svh"

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TIME_BITS-1:0] stamp_ff, stamp_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_kind_ff, rsp_kind_in;
   logic [15:0]          rsp_tag_ff, rsp_tag_in;
   logic [31:0]          rsp_time_ff, rsp_time_in;
   logic [CNT_W-1:0]     rsp_occ_ff, rsp_occ_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 out_free, req_fire, full, load_out;
   cell_op_type          cell_op;
   logic [TIME_BITS-1:0] key;
   logic [TAG_BITS-1:0]  new_tag;
   logic [TIME_BITS-1:0] new_time;

   cell_flags_type       flags [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]  cell_tag [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] cell_time [QUEUE_DEPTH];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign req_fire  = req_valid && !req_stall;
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign key       = (state_ff == ST_RELEASE) ? stamp_ff : TIME_BITS'(req_time_stamp);
   assign new_tag   = TAG_BITS'(req_packet_tag);
   assign new_time  = TIME_BITS'(req_time_stamp);

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                 prev_ge, prev_valid, next_valid;
      logic [TAG_BITS-1:0]  prev_tag, next_tag;
      logic [TIME_BITS-1:0] prev_time, next_time;

      if (i == 0) begin : g_first
         assign prev_ge    = 1'b0;
         assign prev_valid = 1'b0;
         assign prev_tag   = '0;
         assign prev_time  = '0;
      end else begin : g_inner
         assign prev_ge    = flags[i-1].ge;
         assign prev_valid = flags[i-1].valid;
         assign prev_tag   = cell_tag[i-1];
         assign prev_time  = cell_time[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_final
         assign next_valid = 1'b0;
         assign next_tag   = '0;
         assign next_time  = '0;
      end else begin : g_body
         assign next_valid = flags[i+1].valid;
         assign next_tag   = cell_tag[i+1];
         assign next_time  = cell_time[i+1];
      end

      tdq_cell #(
         .TAG_BITS  (TAG_BITS),
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (cell_op),
         .key        (key),
         .new_tag    (new_tag),
         .new_time   (new_time),
         .prev_ge    (prev_ge),
         .prev_valid (prev_valid),
         .prev_tag   (prev_tag),
         .prev_time  (prev_time),
         .next_valid (next_valid),
         .next_tag   (next_tag),
         .next_time  (next_time),
         .flags      (flags[i]),
         .tag        (cell_tag[i]),
         .time_val   (cell_time[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_action == ACT_RELEASE)) begin
               state_in = ST_RELEASE;
            end
         end
         ST_RELEASE: begin
            if (out_free && (!flags[0].rdy || !flags[1].rdy)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cell_op     = CELL_HOLD;
      count_in    = count_ff;
      stamp_in    = stamp_ff;
      load_out    = 1'b0;
      rsp_kind_in = KIND_ACCEPTED;
      rsp_tag_in  = '0;
      rsp_time_in = '0;
      rsp_occ_in  = count_ff;
      rsp_last_in = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_action)
                  ACT_INSERT: begin
                     load_out = 1'b1;
                     if (full) begin
                        rsp_kind_in = KIND_REFUSED;
                     end else begin
                        cell_op    = CELL_INSERT;
                        count_in   = count_ff + CNT_W'(1);
                        rsp_occ_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_RELEASE: begin
                     stamp_in = new_time;
                  end
                  ACT_CLEAR: begin
                     cell_op     = CELL_CLEAR;
                     count_in    = '0;
                     load_out    = 1'b1;
                     rsp_kind_in = KIND_CLEARED;
                     rsp_occ_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RELEASE: begin
            if (out_free) begin
               load_out = 1'b1;
               if (flags[0].rdy) begin
                  cell_op     = CELL_POP;
                  count_in    = count_ff - CNT_W'(1);
                  rsp_kind_in = KIND_RELEASED;
                  rsp_tag_in  = 16'(cell_tag[0]);
                  rsp_time_in = 32'(cell_time[0]);
                  rsp_occ_in  = count_ff - CNT_W'(1);
                  rsp_last_in = !flags[1].rdy;
               end else begin
                  rsp_kind_in = KIND_NONE_READY;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
      if (load_out) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_tag_ff  <= rsp_tag_in;
         rsp_time_ff <= rsp_time_in;
         rsp_occ_ff  <= rsp_occ_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_packet_tag_res = rsp_tag_ff;
   assign rsp_delivery_time  = rsp_time_ff;
   assign rsp_occupancy      = 7'(rsp_occ_ff);
   assign rsp_last           = rsp_last_ff;

   `TRDQ_ASSERT_IMP(a_count_range, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `TRDQ_ASSERT_IMP(a_head_matches_count, 1'b1, (count_ff != '0) == flags[0].valid)
   `TRDQ_ASSERT_NEXT(a_release_continues,
      (state_ff == ST_RELEASE) && load_out && !rsp_last_in, state_ff == ST_RELEASE)
   `TRDQ_ASSERT_IMP(a_pop_only_when_ready, cell_op == CELL_POP, flags[0].rdy && out_free)

endmodule

@@ rtl/tdq_cell.sv @@
// One slot of the sorted chain: holds a tag, a time and an occupied bit.
// Depends on tdq_pkg; instantiated in a row by timed_release_delay_queue.
module tdq_cell import tdq_pkg::*; #(
   parameter int TAG_BITS  = 16,
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_op_type          op,
   input  logic [TIME_BITS-1:0] key,
   input  logic [TAG_BITS-1:0]  new_tag,
   input  logic [TIME_BITS-1:0] new_time,
   input  logic                 prev_ge,
   input  logic                 prev_valid,
   input  logic [TAG_BITS-1:0]  prev_tag,
   input  logic [TIME_BITS-1:0] prev_time,
   input  logic                 next_valid,
   input  logic [TAG_BITS-1:0]  next_tag,
   input  logic [TIME_BITS-1:0] next_time,
   output cell_flags_type       flags,
   output logic [TAG_BITS-1:0]  tag,
   output logic [TIME_BITS-1:0] time_val
);

   logic                 valid_ff, valid_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;
   logic [TIME_BITS-1:0] time_ff, time_in;

   assign flags.valid = valid_ff;
   assign flags.ge    = !valid_ff || (time_ff >= key);
   assign flags.rdy   = valid_ff && (time_ff <= key);
   assign tag         = tag_ff;
   assign time_val    = time_ff;

   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      time_in  = time_ff;
      case (op)
         CELL_INSERT: begin
            if (flags.ge && !prev_ge) begin
               valid_in = 1'b1;
               tag_in   = new_tag;
               time_in  = new_time;
            end else if (flags.ge) begin
               valid_in = prev_valid;
               tag_in   = prev_tag;
               time_in  = prev_time;
            end
         end
         CELL_POP: begin
            valid_in = next_valid;
            tag_in   = next_tag;
            time_in  = next_time;
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      time_ff <= time_in;
   end

endmodule
